### rtl/core/mtws_pkg.sv
// shared types and fixed field widths for the three-window maximum sum block
// no dependencies; imported by max_three_window_sums
package mtws_pkg;

   localparam int SAMPLE_W = 16;  // one sample word
   localparam int K_W      = 9;   // window length register
   localparam int SUM_W    = 26;  // window sums wrap at this width
   localparam int TOT_W    = 28;  // sum of three window sums, no wrap
   localparam int START_W  = 10;  // reported start indices

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FWD,
      ST_BWD,
      ST_MID,
      ST_OUT
   } state_type;

endpackage

### rtl/core/mtws_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mtws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/max_three_window_sums.sv
// top level: best three non-overlapping windows of a loaded sequence
// depends on mtws_pkg and mtws_ram
//
// Samples are loaded one word per cycle; the block stores running prefix sums, so each
// window sum is the difference of two stored prefixes. After the word marked last it
// runs three pipelined passes, each one step per cycle, limited by the single read port
// of each store: a forward pass (n-k+1 steps) and a backward pass (n-k+1 steps) record
// the best window to the left and to the right of every end position, then a middle
// pass (n-3k+1 steps) picks the best total. Each pass drains its pipeline before the next
// one starts, and then the result moves into the output register. A sequence that
// overflows MAX_LEN, is shorter than 3k or has k = 0 skips the passes and reports
// found = 0 with all start indices 0. The stores need no clearing after reset; only
// entries written for the current sequence are read. Input words are refused while the
// passes run; the next sequence may start loading while a result still waits on the
// output.
module max_three_window_sums #(
   parameter int MAX_LEN = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mtws_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [mtws_pkg::START_W-1:0]  rsp_first_start,
   output logic [mtws_pkg::START_W-1:0]  rsp_second_start,
   output logic [mtws_pkg::START_W-1:0]  rsp_third_start,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mtws_pkg::K_W-1:0]      csr_window_length
);
   import mtws_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int LR_W  = IDX_W + SUM_W;
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

   state_type state_ff, state_in;

   logic [K_W-1:0]   window_length_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             found_ff, found_in;

   // issue side of the pass pipeline
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             issue_ff, issue_in;
   logic             first_issue_ff, first_issue_in;
   logic [CNT_W-1:0] last_pos;
   logic [CNT_W-1:0] pos_step;
   logic [CNT_W-1:0] pos_minus_k;
   logic [CNT_W-1:0] pos_plus_k;

   // read data stage and compute stage
   logic             v1_ff;
   logic [CNT_W-1:0] pos1_ff;
   logic             first1_ff;
   logic             sub1_ff;
   logic             v2_ff;
   logic [CNT_W-1:0] pos2_ff;
   logic             first2_ff;
   logic [SUM_W-1:0] ws2_ff, ws2_in;
   logic [IDX_W-1:0] lidx2_ff, ridx2_ff;
   logic [SUM_W-1:0] lval2_ff, rval2_ff;

   // running best and chosen ends
   logic [SUM_W-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [TOT_W-1:0] top_ff, top_in;
   logic [TOT_W-1:0] total;
   logic [IDX_W-1:0] end0_ff, end0_in;
   logic [IDX_W-1:0] end1_ff, end1_in;
   logic [IDX_W-1:0] end2_ff, end2_in;
   logic             take;
   logic             ok;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic               rsp_found_ff;
   logic [START_W-1:0] rsp_first_ff, rsp_second_ff, rsp_third_ff;
   logic [START_W-1:0] start0, start1, start2;

   // memory ports
   logic             req_accept;
   logic             pfx_we;
   logic [SUM_W-1:0] pfx_wdata;
   logic [SUM_W-1:0] pfx_a_rdata, pfx_b_rdata;
   logic             lr_re;
   logic             left_we, right_we;
   logic [LR_W-1:0]  lr_wdata;
   logic [LR_W-1:0]  left_rdata, right_rdata;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_LOAD);
   assign csr_ready  = 1'b1;
   assign pfx_wdata  = sum_ff + SUM_W'(req_sample);
   assign pos_minus_k = pos_ff - k_ff;
   assign pos_plus_k  = pos_ff + k_ff;
   assign lr_re      = issue_ff && (state_ff == ST_MID);
   assign lr_wdata   = {best_idx_in, best_val_in};
   assign ws2_in     = pfx_a_rdata - (sub1_ff ? pfx_b_rdata : '0);
   assign total      = TOT_W'(ws2_ff) + TOT_W'(lval2_ff) + TOT_W'(rval2_ff);

   // prefix sums are kept twice so that two of them can be read each cycle
   mtws_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LEN)) u_pfx_a (
      .clock   (clock),
      .wr_en   (pfx_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (pfx_wdata),
      .rd_en   (issue_ff),
      .rd_addr (pos_ff[IDX_W-1:0]),
      .rd_data (pfx_a_rdata)
   );

   mtws_ram #(.WIDTH(SUM_W), .DEPTH(MAX_LEN)) u_pfx_b (
      .clock   (clock),
      .wr_en   (pfx_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (pfx_wdata),
      .rd_en   (issue_ff),
      .rd_addr (pos_minus_k[IDX_W-1:0]),
      .rd_data (pfx_b_rdata)
   );

   mtws_ram #(.WIDTH(LR_W), .DEPTH(MAX_LEN)) u_left (
      .clock   (clock),
      .wr_en   (left_we),
      .wr_addr (pos2_ff[IDX_W-1:0]),
      .wr_data (lr_wdata),
      .rd_en   (lr_re),
      .rd_addr (pos_minus_k[IDX_W-1:0]),
      .rd_data (left_rdata)
   );

   mtws_ram #(.WIDTH(LR_W), .DEPTH(MAX_LEN)) u_right (
      .clock   (clock),
      .wr_en   (right_we),
      .wr_addr (pos2_ff[IDX_W-1:0]),
      .wr_data (lr_wdata),
      .rd_en   (lr_re),
      .rd_addr (pos_plus_k[IDX_W-1:0]),
      .rd_data (right_rdata)
   );

   // scan direction and final position of each pass
   always_comb begin
      case (state_ff)
         ST_BWD: begin
            last_pos = k_ff - CNT_ONE;
            pos_step = pos_ff - CNT_ONE;
         end
         ST_MID: begin
            last_pos = n_ff - k_ff - CNT_ONE;
            pos_step = pos_ff + CNT_ONE;
         end
         default: begin
            last_pos = n_ff - CNT_ONE;
            pos_step = pos_ff + CNT_ONE;
         end
      endcase
   end

   assign start0 = START_W'(32'(end0_ff) + 32'd1 - 32'(k_ff));
   assign start1 = START_W'(32'(end1_ff) + 32'd1 - 32'(k_ff));
   assign start2 = START_W'(32'(end2_ff) + 32'd1 - 32'(k_ff));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      ovf_in         = ovf_ff;
      n_in           = n_ff;
      k_in           = k_ff;
      found_in       = found_ff;
      pos_in         = pos_ff;
      issue_in       = issue_ff;
      first_issue_in = first_issue_ff;
      best_val_in    = best_val_ff;
      best_idx_in    = best_idx_ff;
      top_in         = top_ff;
      end0_in        = end0_ff;
      end1_in        = end1_ff;
      end2_in        = end2_ff;
      pfx_we         = 1'b0;
      left_we        = 1'b0;
      right_we       = 1'b0;
      rsp_load       = 1'b0;
      take           = 1'b0;
      ok             = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (count_ff < CNT_MAX) begin
                  pfx_we   = 1'b1;
                  sum_in   = pfx_wdata;
                  count_in = count_ff + CNT_ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  n_in = count_in;
                  ok = !ovf_in && (window_length_ff != '0) &&
                       (32'(n_in) >= 32'(window_length_ff) * 32'd3);
                  found_in = ok;
                  k_in     = CNT_W'(window_length_ff);
                  count_in = '0;
                  sum_in   = '0;
                  ovf_in   = 1'b0;
                  if (ok) begin
                     state_in       = ST_FWD;
                     pos_in         = CNT_W'(window_length_ff) - CNT_ONE;
                     issue_in       = 1'b1;
                     first_issue_in = 1'b1;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_FWD, ST_BWD, ST_MID: begin
            if (issue_ff) begin
               first_issue_in = 1'b0;
               pos_in         = pos_step;
               if (pos_ff == last_pos) begin
                  issue_in = 1'b0;
               end
            end else if (!v1_ff && !v2_ff) begin
               // pass drained, start the next one
               case (state_ff)
                  ST_FWD: begin
                     state_in       = ST_BWD;
                     pos_in         = n_ff - CNT_ONE;
                     issue_in       = 1'b1;
                     first_issue_in = 1'b1;
                  end
                  ST_BWD: begin
                     state_in       = ST_MID;
                     pos_in         = (k_ff << 1) - CNT_ONE;
                     issue_in       = 1'b1;
                     first_issue_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // compute stage of the pass pipeline
      if (v2_ff) begin
         case (state_ff)
            ST_FWD: begin
               // strict compare keeps the earliest window on a tie
               take     = first2_ff || (ws2_ff > best_val_ff);
               left_we  = 1'b1;
            end
            ST_BWD: begin
               // scanning downward, >= moves a tie to the earlier window
               take     = first2_ff || (ws2_ff >= best_val_ff);
               right_we = 1'b1;
            end
            ST_MID: begin
               if (first2_ff || (total > top_ff)) begin
                  top_in  = total;
                  end0_in = lidx2_ff;
                  end1_in = pos2_ff[IDX_W-1:0];
                  end2_in = ridx2_ff;
               end
            end
            default: begin
               take = 1'b0;
            end
         endcase
         if (take) begin
            best_val_in = ws2_ff;
            best_idx_in = pos2_ff[IDX_W-1:0];
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= K_W'(1);
         count_ff         <= '0;
         sum_ff           <= '0;
         ovf_ff           <= 1'b0;
         issue_ff         <= 1'b0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_length_ff <= csr_window_length;
         end
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         issue_ff     <= issue_in;
         v1_ff        <= issue_ff;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      k_ff           <= k_in;
      found_ff       <= found_in;
      pos_ff         <= pos_in;
      first_issue_ff <= first_issue_in;
      pos1_ff        <= pos_ff;
      first1_ff      <= first_issue_ff;
      sub1_ff        <= (pos_ff >= k_ff);
      pos2_ff        <= pos1_ff;
      first2_ff      <= first1_ff;
      ws2_ff         <= ws2_in;
      lidx2_ff       <= left_rdata[LR_W-1:SUM_W];
      lval2_ff       <= left_rdata[SUM_W-1:0];
      ridx2_ff       <= right_rdata[LR_W-1:SUM_W];
      rval2_ff       <= right_rdata[SUM_W-1:0];
      best_val_ff    <= best_val_in;
      best_idx_ff    <= best_idx_in;
      top_ff         <= top_in;
      end0_ff        <= end0_in;
      end1_ff        <= end1_in;
      end2_ff        <= end2_in;
      if (rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_first_ff  <= found_ff ? start0 : '0;
         rsp_second_ff <= found_ff ? start1 : '0;
         rsp_third_ff  <= found_ff ? start2 : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_first_start  = rsp_first_ff;
   assign rsp_second_start = rsp_second_ff;
   assign rsp_third_start  = rsp_third_ff;

   // the load counter never runs past the store
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_MAX)
      else $error("load count beyond store depth");

   // reads are only issued while a pass runs
   assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> (state_ff == ST_FWD || state_ff == ST_BWD || state_ff == ST_MID))
      else $error("store read issued outside a pass");

   // the side windows of every middle candidate do not overlap it
   assert property (@(posedge clock) disable iff (reset)
      (v2_ff && state_ff == ST_MID) |->
         (32'(lidx2_ff) + 32'(k_ff) <= 32'(pos2_ff)) &&
         (32'(ridx2_ff) >= 32'(pos2_ff) + 32'(k_ff)))
      else $error("side window overlaps middle window");

   // a found result has three ordered, disjoint windows
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && found_ff) |->
         (32'(end0_ff) + 32'(k_ff) <= 32'(end1_ff)) &&
         (32'(end1_ff) + 32'(k_ff) <= 32'(end2_ff)))
      else $error("chosen windows out of order");

endmodule
